/* sv/pts_pkg.sv */
// ---------------------------------------------------------------------------
// pts_pkg
// Types, codes and constants shared by the priority task scheduler.
// ---------------------------------------------------------------------------
package pts_pkg;

  localparam int DefaultMaxTasks = 8;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_TICK   = 3'd1,
    OP_DELAY  = 3'd2,
    OP_NOTIFY = 3'd3,
    OP_SCHED  = 3'd4,
    OP_FINISH = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    MODE_UNUSED  = 3'd0,
    MODE_READY   = 3'd1,
    MODE_RUNNING = 3'd2,
    MODE_DELAYED = 3'd3,
    MODE_BLOCKED = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2,
    ST_BUSY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_WRITE,
    S_DONE
  } fsm_t;

  // one task table entry
  typedef struct packed {
    logic [2:0]  mode;
    logic [7:0]  prio;
    logic [31:0] delay;
    logic [31:0] notes;
    logic [31:0] runs;
  } entry_t;

endpackage

/* sv/priority_task_scheduler.sv */
// ---------------------------------------------------------------------------
// priority_task_scheduler
// Priority scheduler with delay ticks over a task table memory; no preemption.
// ---------------------------------------------------------------------------
//  channel | handshake        | payload
//  in      | in_valid/in_stall| operation priority_req delay_amount task_index
//  out     | out_valid/out_stall | status selected_valid selected_task
//          |                  | tick_total switch_total counter_value
//
//  add, delay, notify, finish, schedule while a task runs and empty-table scans:
//  one request at a time, in the steps accept, read, write, result
//  tick and schedule: accept, read, table scan, write, result; one table entry
//  read per cycle on the single read port, ticks writing back counted-down delays
//  reset clears the task count and running flag; entries at or above the count are
//  never used, so the memory needs no clearing pass
//  a held result stalls the block until taken; the next request waits
// ---------------------------------------------------------------------------
module priority_task_scheduler import pts_pkg::*; #(
  parameter int MaxTasks = DefaultMaxTasks
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [7:0]  priority_req,
  input  logic [31:0] delay_amount,
  input  logic [3:0]  task_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        selected_valid,
  output logic [2:0]  selected_task,
  output logic [31:0] tick_total,
  output logic [31:0] switch_total,
  output logic [31:0] counter_value
);

  localparam int IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int CntW = $clog2(MaxTasks + 1);

  fsm_t state, state_next;

  logic [2:0]      op;
  logic [7:0]      prio;
  logic [31:0]     amount;
  logic [3:0]      tidx;
  logic [CntW-1:0] count;
  logic            run_valid;
  logic [IdxW-1:0] run_task;
  logic [31:0]     ticks;
  logic [31:0]     switches;
  logic [CntW-1:0] ptr;
  logic            found;
  logic [IdxW-1:0] best;
  logic [7:0]      best_p;
  logic            scan_live;
  logic [IdxW-1:0] cur;

  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;
  logic [IdxW-1:0] raddr;
  entry_t          rdata;

  pts_table #(.MaxTasks(MaxTasks), .IdxW(IdxW)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic notify_ok;
  logic scan_op;
  assign notify_ok = ({{(32-4){1'b0}}, tidx} < 32'(count));
  assign scan_op   = (op == OP_TICK) || (op == OP_SCHED && !run_valid);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_READ;
      S_READ: begin
        if (scan_op) begin
          state_next = (count == '0) ? S_WRITE : S_SCAN;
        end else begin
          state_next = S_WRITE;
        end
      end
      S_SCAN:  if (!scan_live && ptr == count) state_next = S_WRITE;
      S_WRITE: state_next = S_DONE;
      S_DONE:  if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);

  // read address: scan pointer, the addressed task or the running task
  always_comb begin
    raddr = '0;
    case (op)
      OP_NOTIFY: raddr = tidx[IdxW-1:0] & {IdxW{notify_ok}};
      OP_DELAY,
      OP_FINISH: raddr = run_task;
      default:   raddr = ptr[IdxW-1:0];
    endcase
    if (scan_op && ptr >= CntW'(MaxTasks)) raddr = '0;
    // last scan cycle fetches the chosen entry for its write back
    if (state == S_SCAN && op == OP_SCHED && !scan_live) raddr = best;
  end

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = cur;
    wdata = rdata;
    if (state == S_SCAN && scan_live && op == OP_TICK) begin
      if (rdata.mode == MODE_DELAYED && rdata.delay != '0) begin
        we          = 1'b1;
        wdata.delay = rdata.delay - 32'd1;
        if (rdata.delay == 32'd1) wdata.mode = MODE_READY;
      end
    end else if (state == S_WRITE) begin
      case (op)
        OP_ADD: begin
          we    = (count < CntW'(MaxTasks));
          waddr = count[IdxW-1:0];
          wdata = '{mode: MODE_READY, prio: prio, delay: '0, notes: '0, runs: '0};
        end
        OP_DELAY: begin
          we          = run_valid;
          waddr       = run_task;
          wdata.delay = amount;
          wdata.mode  = MODE_DELAYED;
        end
        OP_NOTIFY: begin
          we          = notify_ok;
          waddr       = tidx[IdxW-1:0];
          wdata.notes = rdata.notes + 32'd1;
          if (rdata.mode == MODE_BLOCKED) wdata.mode = MODE_READY;
        end
        OP_SCHED: begin
          we         = !run_valid && found;
          waddr      = best;
          wdata.mode = MODE_RUNNING;
        end
        OP_FINISH: begin
          we         = run_valid;
          waddr      = run_task;
          wdata.runs = rdata.runs + 32'd1;
          if (rdata.mode == MODE_RUNNING) wdata.mode = MODE_READY;
        end
        default: we = 1'b0;
      endcase
    end
  end

  logic sched_write;
  assign sched_write = (state == S_SCAN) && (op == OP_SCHED) && !run_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      run_valid <= 1'b0;
      run_task  <= '0;
      ticks     <= '0;
      switches  <= '0;
      ptr       <= '0;
      scan_live <= 1'b0;
      found     <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op     <= operation;
            prio   <= priority_req;
            amount <= delay_amount;
            tidx   <= task_index;
            ptr    <= '0;
            found  <= 1'b0;
            best   <= '0;
            best_p <= '0;
            scan_live <= 1'b0;
          end
        end
        S_READ, S_SCAN: begin
          // pipelined scan: issue read at ptr, evaluate the registered entry in the next cycle
          if (scan_op) begin
            cur       <= ptr[IdxW-1:0];
            scan_live <= (ptr < count);
            if (ptr < count) ptr <= ptr + CntW'(1);
          end else begin
            cur <= raddr;
          end
          if (sched_write && scan_live && rdata.mode == MODE_READY &&
              (!found || rdata.prio >= best_p)) begin
            found  <= 1'b1;
            best   <= cur;
            best_p <= rdata.prio;
          end
        end
        S_WRITE: begin
          status         <= ST_IGNORED;
          selected_valid <= 1'b0;
          selected_task  <= '0;
          counter_value  <= '0;
          case (op)
            OP_ADD: begin
              if (count < CntW'(MaxTasks)) begin
                status        <= ST_OK;
                selected_task <= 3'(count);
                count         <= count + CntW'(1);
              end else begin
                status <= ST_FULL;
              end
            end
            OP_TICK: status <= ST_OK;
            OP_DELAY: begin
              if (run_valid) begin
                status        <= ST_OK;
                selected_task <= 3'(run_task);
              end
            end
            OP_NOTIFY: begin
              if (notify_ok) begin
                status        <= ST_OK;
                selected_task <= 3'(tidx);
                counter_value <= rdata.notes + 32'd1;
              end
            end
            OP_SCHED: begin
              if (run_valid) begin
                status        <= ST_BUSY;
                selected_task <= 3'(run_task);
              end else if (found) begin
                status         <= ST_OK;
                selected_valid <= 1'b1;
                selected_task  <= 3'(best);
                run_valid      <= 1'b1;
                run_task       <= best;
                switches       <= switches + 32'd1;
              end
            end
            OP_FINISH: begin
              if (run_valid) begin
                status        <= ST_OK;
                selected_task <= 3'(run_task);
                counter_value <= rdata.runs + 32'd1;
                run_valid     <= 1'b0;
                run_task      <= '0;
              end
            end
            default: status <= ST_IGNORED;
          endcase
          if (op == OP_TICK) begin
            ticks <= ticks + 32'd1;
          end
        end
        default: ;
      endcase
    end
  end

  assign tick_total   = ticks;
  assign switch_total = switches;

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MaxTasks)) else $error("task count overflow");
  a_run_in_table: assert property (@(posedge clk) disable iff (rst)
    run_valid |-> (CntW'(run_task) < count)) else $error("running task outside table");
  a_in_out_excl: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("accepting while result pending");
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && op == OP_TICK) |=> ticks == $past(ticks) + 32'd1)
    else $error("tick count step");

endmodule

/* sv/pts_table.sv */
// ---------------------------------------------------------------------------
// pts_table
// Task table memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pts_table import pts_pkg::*; #(
  parameter int MaxTasks = DefaultMaxTasks,
  parameter int IdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [IdxW-1:0] waddr,
  input  entry_t          wdata,
  input  logic [IdxW-1:0] raddr,
  output entry_t          rdata
);

  entry_t mem [MaxTasks];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sim/tb_priority_task_scheduler.sv */
// ---------------------------------------------------------------------------
// tb_priority_task_scheduler
// Drives scheduler events (add, tick, delay, notify, schedule, finish) and
// undefined op codes, with random idling on both channels; predicts each result
// from a task table model and compares every result field by field in order.
// ---------------------------------------------------------------------------
module tb_priority_task_scheduler;
  import pts_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumTasks = DefaultMaxTasks;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic        selected_valid;
    logic [2:0]  selected_task;
    logic [31:0] tick_total;
    logic [31:0] switch_total;
    logic [31:0] counter_value;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic [7:0]  priority_req = '0;
  logic [31:0] delay_amount = '0;
  logic [3:0]  task_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic        selected_valid;
  logic [2:0]  selected_task;
  logic [31:0] tick_total;
  logic [31:0] switch_total;
  logic [31:0] counter_value;

  mode_t       mdl_mode [NumTasks];
  logic [7:0]  mdl_prio [NumTasks];
  logic [31:0] mdl_delay [NumTasks];
  logic [31:0] mdl_notes [NumTasks];
  logic [31:0] mdl_runs [NumTasks];
  int          mdl_count;
  int          mdl_running;
  bit          mdl_running_valid;
  logic [31:0] mdl_ticks;
  logic [31:0] mdl_switches;

  outcome_t    pending_outcomes[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  priority_task_scheduler i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic outcome_t predict_event(logic [2:0] op, logic [7:0] pr,
                                             logic [31:0] amt, logic [3:0] idx);
    outcome_t r;
    int best;
    r = '0;
    r.status = ST_IGNORED;
    best = -1;
    case (op)
      OP_ADD: begin
        if (mdl_count >= NumTasks) begin
          r.status = ST_FULL;
        end else begin
          mdl_prio[mdl_count] = pr;
          mdl_mode[mdl_count] = MODE_READY;
          mdl_delay[mdl_count] = '0;
          mdl_runs[mdl_count] = '0;
          mdl_notes[mdl_count] = '0;
          r.selected_task = mdl_count[2:0];
          mdl_count++;
          r.status = ST_OK;
        end
      end
      OP_TICK: begin
        mdl_ticks++;
        for (int i = 0; i < mdl_count; i++) begin
          if (mdl_mode[i] == MODE_DELAYED && mdl_delay[i] != 0) begin
            mdl_delay[i]--;
            if (mdl_delay[i] == 0) mdl_mode[i] = MODE_READY;
          end
        end
        r.status = ST_OK;
      end
      OP_DELAY: begin
        if (mdl_running_valid) begin
          mdl_delay[mdl_running] = amt;
          mdl_mode[mdl_running] = MODE_DELAYED;
          r.selected_task = mdl_running[2:0];
          r.status = ST_OK;
        end
      end
      OP_NOTIFY: begin
        if (idx < mdl_count) begin
          mdl_notes[idx]++;
          if (mdl_mode[idx] == MODE_BLOCKED) mdl_mode[idx] = MODE_READY;
          r.counter_value = mdl_notes[idx];
          r.selected_task = idx[2:0];
          r.status = ST_OK;
        end
      end
      OP_SCHED: begin
        if (mdl_running_valid) begin
          r.status = ST_BUSY;
          r.selected_task = mdl_running[2:0];
        end else begin
          for (int i = 0; i < mdl_count; i++)
            if (mdl_mode[i] == MODE_READY && (best < 0 || mdl_prio[i] >= mdl_prio[best]))
              best = i;
          if (best >= 0) begin
            mdl_running = best;
            mdl_running_valid = 1'b1;
            mdl_mode[best] = MODE_RUNNING;
            mdl_switches++;
            r.selected_valid = 1'b1;
            r.selected_task = best[2:0];
            r.status = ST_OK;
          end
        end
      end
      OP_FINISH: begin
        if (mdl_running_valid) begin
          if (mdl_mode[mdl_running] == MODE_RUNNING) mdl_mode[mdl_running] = MODE_READY;
          mdl_runs[mdl_running]++;
          r.counter_value = mdl_runs[mdl_running];
          r.selected_task = mdl_running[2:0];
          mdl_running_valid = 1'b0;
          mdl_running = 0;
          r.status = ST_OK;
        end
      end
      default: ;
    endcase
    r.tick_total = mdl_ticks;
    r.switch_total = mdl_switches;
    return r;
  endfunction

  task automatic send_request(logic [2:0] op, logic [7:0] pr = '0,
                              logic [31:0] amt = '0, logic [3:0] idx = '0);
    int gap;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    priority_req <= pr;
    delay_amount <= amt;
    task_index <= idx;
    do @(posedge clk); while (in_stall);
    pending_outcomes.push_back(predict_event(op, pr, amt, idx));
  endtask

  // result stall bursts
  initial begin
    int len;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 17);
        out_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = pending_outcomes.pop_front();
        if (status !== e.status) begin
          $error("status exp %0d got %0d", e.status, status); errors++;
        end
        if (selected_valid !== e.selected_valid) begin
          $error("selected_valid exp %0d got %0d", e.selected_valid, selected_valid);
          errors++;
        end
        if (selected_task !== e.selected_task) begin
          $error("selected_task exp %0d got %0d", e.selected_task, selected_task);
          errors++;
        end
        if (tick_total !== e.tick_total) begin
          $error("tick_total exp %0d got %0d", e.tick_total, tick_total); errors++;
        end
        if (switch_total !== e.switch_total) begin
          $error("switch_total exp %0d got %0d", e.switch_total, switch_total); errors++;
        end
        if (counter_value !== e.counter_value) begin
          $error("counter_value exp %0d got %0d", e.counter_value, counter_value);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_request(OP_SCHED);
    send_request(OP_DELAY, 8'h00, 32'hFFFF_FFFF);
    send_request(OP_FINISH);
    send_request(OP_NOTIFY, 8'h00, '0, 4'd0);
    send_request(3'd6, 8'hFF, 32'hFFFF_FFFF, 4'hF);
    send_request(3'd7);
  endtask

  task automatic test_directed();
    send_request(OP_ADD, 8'h00);
    send_request(OP_ADD, 8'hFF);
    send_request(OP_ADD, 8'hFF);
    send_request(OP_SCHED);
    send_request(OP_SCHED);
    send_request(OP_DELAY, '0, 32'd2);
    send_request(OP_SCHED);
    send_request(OP_DELAY, '0, 32'd0);
    send_request(OP_TICK);
    send_request(OP_TICK);
    send_request(OP_NOTIFY, '0, '0, 4'd1);
    send_request(OP_NOTIFY, '0, '0, 4'hF);
    send_request(OP_SCHED);
    send_request(OP_FINISH);
    send_request(OP_FINISH);
    for (int i = 0; i < 6; i++) send_request(OP_ADD, 8'(i * 40));
    send_request(OP_SCHED);
    send_request(OP_FINISH);
  endtask

  task automatic test_random(int n);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 2) send_request(OP_ADD, 8'($urandom));
      else if (roll < 30) send_request(OP_TICK);
      else if (roll < 45)
        send_request(OP_DELAY, '0, ($urandom_range(0, 9) == 0) ? $urandom
                     : 32'($urandom_range(0, 6)));
      else if (roll < 58) send_request(OP_NOTIFY, 8'($urandom), $urandom,
                                       4'($urandom));
      else if (roll < 78) send_request(OP_SCHED, 8'($urandom));
      else if (roll < 97) send_request(OP_FINISH);
      else send_request(3'($urandom_range(6, 7)), 8'($urandom), $urandom, 4'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NumTasks; i++) begin
      mdl_mode[i] = MODE_UNUSED;
      mdl_prio[i] = '0;
      mdl_delay[i] = '0;
      mdl_notes[i] = '0;
      mdl_runs[i] = '0;
    end
    mdl_count = 0;
    mdl_running = 0;
    mdl_running_valid = 1'b0;
    mdl_ticks = '0;
    mdl_switches = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_directed();
    test_random(1100);
    quiet = 1'b1;
    test_random(150);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
